### rtl/bms_pkg.sv
// Shared types, constants and rounding helpers for the bicycle model step.
// Used by bms_sincos and bicycle_model_state_step; depends on nothing.
`default_nettype none

package bms_pkg;

  localparam int DataW        = 32;
  localparam int StepW        = 16;
  localparam int CordicStages = 16;
  localparam int AngW         = 34;   // Q2.30 angle and CORDIC x/y, with headroom
  localparam int ProdW        = 66;   // raw products
  localparam int TermW        = 50;   // rounded terms and sums

  // heading reduction (4) + rotations + sign fold (1)
  localparam int ScLat     = 4 + CordicStages + 1;
  localparam int PipeDepth = ScLat + 5;

  localparam int InTdataW  = 8 * DataW;
  localparam int OutTdataW = 6 * DataW;

  localparam logic [StepW-1:0] StepTimeRst = 16'd6554;
  // dt^2, dt^3 and dt^3/6 for the reset step time
  localparam logic [StepW-1:0] T2Rst  = 16'd655;
  localparam logic [StepW-1:0] T3Rst  = 16'd66;
  localparam logic [StepW-1:0] T3sRst = 16'd11;
  localparam logic [StepW-1:0] Div6Mul = 16'd43691;  // 2^18/6, exact below 2^17

  localparam logic [63:0] InvTwoPi = 64'h28BE60DB9391054A;  // 1/(2pi), Q0.64
  localparam logic [31:0] TwoPiQ29 = 32'd3373259426;
  localparam logic signed [AngW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [AngW-1:0]  ang_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [TermW-1:0] term_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t heading;
    word_t speed;
    word_t yaw_rate;
    word_t accel;
    word_t yaw_accel;
    word_t jerk_in;
  } fld_t;

  // p / 2^sh rounded to nearest, ties away from zero; sh >= 1
  function automatic logic signed [79:0] round_shift(input logic signed [79:0] p,
                                                     input logic [5:0] sh);
    logic [79:0] mag;
    logic [79:0] q;
    mag = p[79] ? $unsigned(-p) : $unsigned(p);
    q = (mag + (80'd1 << (sh - 6'd1))) >> sh;
    return p[79] ? -$signed(q) : $signed(q);
  endfunction

  function automatic word_t sat_word(input term_t v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/bms_sincos.sv
// Pipelined cosine/sine of a Q16.16 heading: reduction modulo 2pi, CORDIC.
// Depends on bms_pkg. ScLat register stages, advancing on en_i.
`default_nettype none

module bms_sincos (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire bms_pkg::word_t   heading_i,
  output bms_pkg::ang_t         cos_o,
  output bms_pkg::ang_t         sin_o
);
  import bms_pkg::*;

  function automatic ang_t atan_q30(input int i);
    case (i)
      0:  return 34'sd843314856;
      1:  return 34'sd497837829;
      2:  return 34'sd263043836;
      3:  return 34'sd133525158;
      4:  return 34'sd67021686;
      5:  return 34'sd33543515;
      6:  return 34'sd16775850;
      7:  return 34'sd8388437;
      8:  return 34'sd4194282;
      9:  return 34'sd2097149;
      10: return 34'sd1048575;
      11: return 34'sd524287;
      12: return 34'sd262143;
      13: return 34'sd131071;
      14: return 34'sd65535;
      15: return 34'sd32767;
      16: return 34'sd16383;
      17: return 34'sd8191;
      18: return 34'sd4095;
      19: return 34'sd2047;
      20: return 34'sd1023;
      21: return 34'sd511;
      22: return 34'sd255;
      23: return 34'sd127;
      24: return 34'sd63;
      25: return 34'sd31;
      26: return 34'sd15;
      27: return 34'sd7;
      28: return 34'sd3;
      29: return 34'sd1;
      default: return '0;
    endcase
  endfunction

  // stage 1: heading times 1/(2pi), split into two 32-bit halves of the constant
  logic signed [64:0] pa_q, pb_q;
  // stage 2: fraction of a turn, Q0.32
  logic signed [31:0] t_q;
  // stage 3: folded turn times 2pi
  logic [62:0]        prod_q;
  logic               neg3_q, flip3_q;
  // stage 4: angle in Q2.30
  ang_t               ang_q;
  logic               flip4_q;
  // rotations
  ang_t               cx_q [CordicStages];
  ang_t               cy_q [CordicStages];
  ang_t               ca_q [CordicStages];
  logic               cf_q [CordicStages];
  ang_t               cos_q, sin_q;

  logic signed [96:0] turn_sum;
  logic signed [32:0] t_fold;
  logic               flip_d;
  logic [30:0]        t_mag;
  logic [31:0]        ang_mag;
  ang_t               cx_d [CordicStages];
  ang_t               cy_d [CordicStages];
  ang_t               ca_d [CordicStages];
  ang_t               xi [CordicStages];
  ang_t               yi [CordicStages];
  ang_t               ai [CordicStages];

  always_comb begin
    turn_sum = $signed({pa_q, 32'b0}) + $signed({{32{pb_q[64]}}, pb_q});

    t_fold = {t_q[31], t_q};
    flip_d = 1'b0;
    if (t_q > 32'sd1073741824) begin
      t_fold = {t_q[31], t_q} - 33'sd2147483648;
      flip_d = 1'b1;
    end else if (t_q < -32'sd1073741824) begin
      t_fold = {t_q[31], t_q} + 33'sd2147483648;
      flip_d = 1'b1;
    end
    t_mag = t_fold[32] ? 31'(-t_fold) : t_fold[30:0];

    ang_mag = 32'((prod_q + 63'd1073741824) >> 31);
  end

  always_comb begin
    xi[0] = CordicGain;
    yi[0] = '0;
    ai[0] = ang_q;
    for (int i = 1; i < CordicStages; i++) begin
      xi[i] = cx_q[i-1];
      yi[i] = cy_q[i-1];
      ai[i] = ca_q[i-1];
    end
    for (int i = 0; i < CordicStages; i++) begin
      if (!ai[i][AngW-1]) begin
        cx_d[i] = xi[i] - (yi[i] >>> i);
        cy_d[i] = yi[i] + (xi[i] >>> i);
        ca_d[i] = ai[i] - atan_q30(i);
      end else begin
        cx_d[i] = xi[i] + (yi[i] >>> i);
        cy_d[i] = yi[i] - (xi[i] >>> i);
        ca_d[i] = ai[i] + atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= heading_i * $signed({1'b0, InvTwoPi[63:32]});
      pb_q    <= heading_i * $signed({1'b0, InvTwoPi[31:0]});
      t_q     <= turn_sum[79:48];
      prod_q  <= 63'(t_mag) * 63'(TwoPiQ29);
      neg3_q  <= t_fold[32];
      flip3_q <= flip_d;
      ang_q   <= neg3_q ? -$signed({2'b00, ang_mag}) : $signed({2'b00, ang_mag});
      flip4_q <= flip3_q;
      for (int i = 0; i < CordicStages; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        ca_q[i] <= ca_d[i];
        cf_q[i] <= (i == 0) ? flip4_q : cf_q[(i == 0) ? 0 : i - 1];
      end
      cos_q <= cf_q[CordicStages-1] ? -cx_q[CordicStages-1] : cx_q[CordicStages-1];
      sin_q <= cf_q[CordicStages-1] ? -cy_q[CordicStages-1] : cy_q[CordicStages-1];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

### rtl/bicycle_model_state_step.sv
// Bicycle model state step. Stages from input word to output register: 1 input
// stage, 21 for heading reduction and CORDIC, 4 multiply/round, 1 sum.
// Throughput: one word per cycle; the pipeline moves as one and stalls only when
// the two-entry output buffer is full. Reset (async, active low) empties the
// pipeline and sets step time to 6554 (about 0.1 s).
`default_nettype none

module bicycle_model_state_step (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [bms_pkg::StepW-1:0]          cfg_wdata_i,    // step_time, Q0.16
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // pos_x, pos_y, heading, speed, yaw_rate, accel, yaw_accel, jerk_in
  input  wire [bms_pkg::InTdataW-1:0]       s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // next_x, next_y, next_heading, next_speed, next_yaw_rate, next_accel
  output logic [bms_pkg::OutTdataW-1:0]     m_axis_tdata_o
);
  import bms_pkg::*;

  localparam logic [5:0] TermSh [12] = '{6'd16, 6'd17, 6'd16, 6'd16, 6'd17, 6'd16,
                                         6'd16, 6'd17, 6'd16, 6'd17, 6'd16, 6'd16};

  // step time and derived powers
  logic [StepW-1:0] dt_q, t2_q, t3_q, t3s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= StepTimeRst;
      t2_q  <= T2Rst;
      t3_q  <= T3Rst;
      t3s_q <= T3sRst;
    end else begin
      if (cfg_we_i) begin
        dt_q <= cfg_wdata_i;
      end
      t2_q  <= 16'((33'(dt_q) * 33'(dt_q) + 33'd32768) >> 16);
      t3_q  <= 16'((33'(t2_q) * 33'(dt_q) + 33'd32768) >> 16);
      t3s_q <= 16'(((33'(t3_q) + 33'd3) * 33'(Div6Mul)) >> 18);
    end
  end

  // pipeline control
  logic en;
  logic vld_q [PipeDepth];
  logic out_vld_q, skid_vld_q;
  logic [OutTdataW-1:0] out_data_q, skid_data_q, res_word;

  assign en = !skid_vld_q;
  assign s_axis_tready_o = en;

  // payload stages
  fld_t  fld_q [ScLat+1];
  ang_t  cos_w, sin_w;
  fld_t  f22_q, f23_q;
  prod_t vc_p_q, vs_p_q, vw_p_q, vwr_p_q;
  ang_t  vc_q, vs_q;
  logic signed [47:0] vw_q, vwr_q;
  prod_t p_q [12];
  word_t b24_q [6], b25_q [6];
  term_t r_q [12];

  fld_t  fld_in;
  logic signed [79:0] rnd_vc, rnd_vs, rnd_vw, rnd_vwr;
  logic signed [79:0] rnd_t [12];
  logic signed [StepW:0] dts, t2s, t3ss;
  term_t s_x, s_y, s_h, s_v, s_w, s_a;

  always_comb begin
    fld_in.pos_x     = s_axis_tdata_i[0*DataW +: DataW];
    fld_in.pos_y     = s_axis_tdata_i[1*DataW +: DataW];
    fld_in.heading   = s_axis_tdata_i[2*DataW +: DataW];
    fld_in.speed     = s_axis_tdata_i[3*DataW +: DataW];
    fld_in.yaw_rate  = s_axis_tdata_i[4*DataW +: DataW];
    fld_in.accel     = s_axis_tdata_i[5*DataW +: DataW];
    fld_in.yaw_accel = s_axis_tdata_i[6*DataW +: DataW];
    fld_in.jerk_in   = s_axis_tdata_i[7*DataW +: DataW];

    dts  = $signed({1'b0, dt_q});
    t2s  = $signed({1'b0, t2_q});
    t3ss = $signed({1'b0, t3s_q});

    rnd_vc  = round_shift({{14{vc_p_q[ProdW-1]}}, vc_p_q}, 6'd30);
    rnd_vs  = round_shift({{14{vs_p_q[ProdW-1]}}, vs_p_q}, 6'd30);
    rnd_vw  = round_shift({{14{vw_p_q[ProdW-1]}}, vw_p_q}, 6'd16);
    rnd_vwr = round_shift({{14{vwr_p_q[ProdW-1]}}, vwr_p_q}, 6'd16);
    for (int k = 0; k < 12; k++) begin
      rnd_t[k] = round_shift({{14{p_q[k][ProdW-1]}}, p_q[k]}, TermSh[k]);
    end

    s_x = TermW'(b25_q[0]) + r_q[0] + r_q[1] + r_q[2];
    s_y = TermW'(b25_q[1]) + r_q[3] + r_q[4] + r_q[5];
    s_h = TermW'(b25_q[2]) + r_q[6] + r_q[7];
    s_v = TermW'(b25_q[3]) + r_q[8] + r_q[9];
    s_w = TermW'(b25_q[4]) + r_q[10];
    s_a = TermW'(b25_q[5]) + r_q[11];
    res_word = {sat_word(s_a), sat_word(s_w), sat_word(s_v),
                sat_word(s_h), sat_word(s_y), sat_word(s_x)};
  end

  bms_sincos u_sincos (
    .clk_i     (clk_i),
    .en_i      (en),
    .heading_i (fld_q[0].heading),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fld_q[0] <= fld_in;
      for (int k = 1; k <= ScLat; k++) begin
        fld_q[k] <= fld_q[k-1];
      end
      // products of speed with cosine, sine, yaw rate and yaw accel
      f22_q   <= fld_q[ScLat];
      vc_p_q  <= prod_t'(fld_q[ScLat].speed * cos_w);
      vs_p_q  <= prod_t'(fld_q[ScLat].speed * sin_w);
      vw_p_q  <= prod_t'(fld_q[ScLat].speed * fld_q[ScLat].yaw_rate);
      vwr_p_q <= prod_t'(fld_q[ScLat].speed * fld_q[ScLat].yaw_accel);
      // rounding
      f23_q <= f22_q;
      vc_q  <= rnd_vc[AngW-1:0];
      vs_q  <= rnd_vs[AngW-1:0];
      vw_q  <= rnd_vw[47:0];
      vwr_q <= rnd_vwr[47:0];
      // step-time products and their rounding; base fields carried alongside
      p_q[0]  <= prod_t'(vc_q * dts);
      p_q[1]  <= prod_t'(f23_q.accel * t2s);
      p_q[2]  <= prod_t'(f23_q.jerk_in * t3ss);
      p_q[3]  <= prod_t'(vs_q * dts);
      p_q[4]  <= prod_t'(vw_q * t2s);
      p_q[5]  <= prod_t'(vwr_q * t3ss);
      p_q[6]  <= prod_t'(f23_q.yaw_rate * dts);
      p_q[7]  <= prod_t'(f23_q.yaw_accel * t2s);
      p_q[8]  <= prod_t'(f23_q.accel * dts);
      p_q[9]  <= prod_t'(f23_q.jerk_in * t2s);
      p_q[10] <= prod_t'(f23_q.yaw_accel * dts);
      p_q[11] <= prod_t'(f23_q.jerk_in * dts);
      b24_q[0] <= f23_q.pos_x;
      b24_q[1] <= f23_q.pos_y;
      b24_q[2] <= f23_q.heading;
      b24_q[3] <= f23_q.speed;
      b24_q[4] <= f23_q.yaw_rate;
      b24_q[5] <= f23_q.accel;
      for (int k = 0; k < 12; k++) begin
        r_q[k] <= rnd_t[k][TermW-1:0];
      end
      for (int k = 0; k < 6; k++) begin
        b25_q[k] <= b24_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PipeDepth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < PipeDepth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // output register plus one skid word
  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_free) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (vld_q[PipeDepth-1]) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_data_q <= skid_data_q;
      end
    end else if (vld_q[PipeDepth-1]) begin
      if (out_free) begin
        out_data_q <= res_word;
      end else begin
        skid_data_q <= res_word;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held while output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready_i && vld_q[PipeDepth-1]))
    else $error("skid filled without a stalled output");

  a_coef_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(cfg_we_i, 1) && !$past(cfg_we_i, 2) && !$past(cfg_we_i, 3) &&
     !$past(cfg_we_i, 4)) |->
    ((19'(t3s_q) * 19'd6 <= 19'(t3_q) + 19'd3) &&
     (19'(t3_q) + 19'd3 < 19'(t3s_q) * 19'd6 + 19'd6)))
    else $error("dt^3/6 out of step with dt^3");
`endif

endmodule

`default_nettype wire
